// File: hw/rtl/configurable_crc_engine_assert.svh
// Assertion macros shared by the CRC engine RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONFIGURABLE_CRC_ENGINE_ASSERT_SVH
`define CONFIGURABLE_CRC_ENGINE_ASSERT_SVH

// Checked only out of reset.
`define CCRC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CCRC_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/ccrc_pkg.sv
// Package for the configurable CRC engine: width codes, register indexes,
// reset values, config struct and the width mask function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccrc_pkg;

	localparam int CRC_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 2;
	localparam int INDEX_W = 3;

	typedef logic [CODE_W-1:0]  width_code_t;
	typedef logic [INDEX_W-1:0] cfg_index_t;
	typedef logic [CRC_W-1:0]   crc_word_t;

	// width codes
	localparam width_code_t WIDTH_8   = 2'd0;
	localparam width_code_t WIDTH_16  = 2'd1;
	localparam width_code_t WIDTH_32  = 2'd2;
	localparam width_code_t WIDTH_BAD = 2'd3;

	// register indexes
	localparam cfg_index_t REG_WIDTH_CODE = 3'd0;
	localparam cfg_index_t REG_POLYNOMIAL = 3'd1;
	localparam cfg_index_t REG_INIT_VALUE = 3'd2;
	localparam cfg_index_t REG_OUTPUT_XOR = 3'd3;
	localparam cfg_index_t REG_LSB_FIRST  = 3'd4;

	// reset values (CRC-16/CCITT-FALSE preset)
	localparam width_code_t RST_WIDTH_CODE = WIDTH_16;
	localparam crc_word_t   RST_POLYNOMIAL = 32'h0000_1021;
	localparam crc_word_t   RST_INIT_VALUE = 32'h0000_FFFF;
	localparam crc_word_t   RST_OUTPUT_XOR = 32'h0000_0000;
	localparam logic        RST_LSB_FIRST  = 1'b0;

	typedef struct packed {
		width_code_t width_code;
		crc_word_t   polynomial;
		logic        lsb_first;
	} crc_cfg_t;

	function automatic crc_word_t width_mask(input width_code_t code);
		crc_word_t m;
		case (code)
			WIDTH_8:  m = 32'h0000_00FF;
			WIDTH_16: m = 32'h0000_FFFF;
			WIDTH_32: m = 32'hFFFF_FFFF;
			default:  m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/configurable_crc_engine.sv
// Configurable CRC-8/16/32 engine. Takes at most one message byte per item and
// accepts an item every cycle when the result side keeps up. An accepted
// item sits in one input register; as it leaves, the byte XOR network
// (eight bit steps) updates the running CRC register, and a last item
// loads the result register, so a result is valid in the cycle after its
// last item leaves the input register; a stalled result can hold it there.
// The per-item rate is set by the loop through the running CRC register.
// Config registers take effect on the next item; write them only while the
// engine is idle. Depends on ccrc_pkg, ccrc_byte_step and configurable_crc_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

module configurable_crc_engine
	import ccrc_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	// config write port
	input  wire              cfg_we,
	input  wire [INDEX_W-1:0] cfg_index,
	input  wire [CRC_W-1:0]  cfg_data,
	// input items
	input  wire              in_valid,
	output logic             in_ready,
	input  wire [BYTE_W-1:0] data_byte,
	input  wire              has_byte,
	input  wire              last_item,
	// results
	output logic             out_valid,
	input  wire              out_ready,
	output logic [CRC_W-1:0] crc_value,
	output logic             config_error
);

	`include "configurable_crc_engine_assert.svh"

	// config registers
	width_code_t width_code_q;
	crc_word_t   polynomial_q;
	crc_word_t   init_value_q;
	crc_word_t   output_xor_q;
	logic        lsb_first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q <= RST_WIDTH_CODE;
			polynomial_q <= RST_POLYNOMIAL;
			init_value_q <= RST_INIT_VALUE;
			output_xor_q <= RST_OUTPUT_XOR;
			lsb_first_q  <= RST_LSB_FIRST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH_CODE: width_code_q <= cfg_data[CODE_W-1:0];
				REG_POLYNOMIAL: polynomial_q <= cfg_data;
				REG_INIT_VALUE: init_value_q <= cfg_data;
				REG_OUTPUT_XOR: output_xor_q <= cfg_data;
				REG_LSB_FIRST:  lsb_first_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              has_byte_s1;
	logic              last_s1;
	logic              s1_fire;
	logic              in_fire;

	assign s1_fire  = valid_s1 && (!last_s1 || !out_valid || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1     <= data_byte;
			has_byte_s1 <= has_byte;
			last_s1     <= last_item;
		end
	end

	// running CRC update
	crc_word_t crc_q;
	logic      msg_open_q;
	crc_word_t mask;
	crc_word_t base_crc;
	crc_word_t stepped_crc;
	crc_word_t next_crc;
	logic      width_ok;
	crc_cfg_t  step_cfg;

	assign width_ok = (width_code_q != WIDTH_BAD);
	assign mask     = width_mask(width_code_q);
	assign base_crc = msg_open_q ? crc_q : (init_value_q & mask);
	assign next_crc = has_byte_s1 ? stepped_crc : base_crc;

	always_comb begin
		step_cfg.width_code = width_code_q;
		step_cfg.polynomial = polynomial_q;
		step_cfg.lsb_first  = lsb_first_q;
	end

	ccrc_byte_step u_step (
		.cfg    (step_cfg),
		.crc_in (base_crc),
		.byte_in(byte_s1),
		.crc_out(stepped_crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= '0;
			msg_open_q <= 1'b0;
		end else if (s1_fire) begin
			if (width_ok) begin
				crc_q      <= next_crc;
				msg_open_q <= !last_s1;
			end else if (last_s1) begin
				msg_open_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			crc_value    <= width_ok ? ((next_crc ^ output_xor_q) & mask) : '0;
			config_error <= !width_ok;
		end
	end

	`CCRC_ASSERT(a_last_gives_result, s1_fire && last_s1 |=> out_valid, "last item lost its result")
	`CCRC_ASSERT(a_last_closes_msg, s1_fire && last_s1 |=> !msg_open_q, "message left open")
	`CCRC_ASSERT(a_err_zero_crc, out_valid && config_error |-> crc_value == '0, "error result not zero")
	`CCRC_ASSERT(a_stall_blocks, valid_s1 && last_s1 && out_valid && !out_ready |-> !in_ready, "input taken over stalled last item")
	`CCRC_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid && !valid_s1, "valid during reset")

endmodule

`default_nettype wire

// File: hw/rtl/ccrc_byte_step.sv
// One byte of CRC update: eight bit steps unrolled into one XOR network.
// Depends on ccrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccrc_byte_step
	import ccrc_pkg::*;
(
	input  wire crc_cfg_t  cfg,
	input  wire crc_word_t crc_in,
	input  wire [BYTE_W-1:0] byte_in,
	output crc_word_t      crc_out
);

	always_comb begin
		crc_word_t c;
		crc_word_t byte_pos;
		logic      fb;
		c = crc_in;
		// byte placement under the top bit for msb-first
		case (cfg.width_code)
			WIDTH_8:  byte_pos = {{(CRC_W-BYTE_W){1'b0}}, byte_in};
			WIDTH_16: byte_pos = {{(CRC_W-16){1'b0}}, byte_in, 8'h00};
			default:  byte_pos = {byte_in, {(CRC_W-BYTE_W){1'b0}}};
		endcase
		if (cfg.lsb_first) begin
			c = c ^ {{(CRC_W-BYTE_W){1'b0}}, byte_in};
			for (int i = 0; i < BYTE_W; i++) begin
				fb = c[0];
				c  = fb ? ((c >> 1) ^ cfg.polynomial) : (c >> 1);
			end
		end else begin
			c = c ^ byte_pos;
			for (int i = 0; i < BYTE_W; i++) begin
				case (cfg.width_code)
					WIDTH_8:  fb = c[7];
					WIDTH_16: fb = c[15];
					default:  fb = c[CRC_W-1];
				endcase
				c = fb ? ((c << 1) ^ cfg.polynomial) : (c << 1);
			end
		end
		crc_out = c & width_mask(cfg.width_code);
	end

endmodule

`default_nettype wire
